@@ hw/rtl/wsd_pkg.sv @@
package wsd_pkg;

    // Second header byte: 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Byte index of the last byte of each multi-byte header field
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    typedef struct packed {
        logic [7:0] stream_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_data;
        logic [3:0] frame_opcode;
        logic       final_fragment;
        logic       end_of_frame;
    } out_item_t;

endpackage

@@ hw/rtl/wsd_stream_if.sv @@
interface wsd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

@@ hw/rtl/wsd_frame_parser.sv @@
module wsd_frame_parser
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] stream_byte,
    output logic       emit,
    output out_item_t  result
);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [2:0]               count_reg, count_next;
    logic [LENGTH_BITS-1:0]   rem_reg, rem_next;
    logic                     ovf_reg, ovf_next;
    logic [31:0]              key_reg, key_next;
    logic [1:0]               pos_reg, pos_next;
    logic [3:0]               opcode_reg, opcode_next;
    logic                     fin_reg, fin_next;
    logic                     masked_reg, masked_next;
    logic                     long_reg, long_next;

    logic [6:0]               code;
    logic [LENGTH_BITS-1:0]   shifted;
    logic [LENGTH_BITS-1:0]   len_sat;
    logic [LENGTH_BITS-1:0]   len_final;
    logic                     hdr_done;
    logic [7:0]               key_byte;

    // Next-state and result for the byte at the input
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        ovf_next    = ovf_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        masked_next = masked_reg;
        long_next   = long_reg;
        hdr_done    = 1'b0;
        len_final   = rem_reg;
        emit        = 1'b0;
        code        = stream_byte[6:0];
        shifted     = {rem_reg[LENGTH_BITS-9:0], stream_byte};
        len_sat     = shifted;
        key_byte    = 8'h00;
        result      = '{payload_byte: 8'h00, has_data: 1'b0, frame_opcode: opcode_reg,
                        final_fragment: fin_reg, end_of_frame: 1'b0};

        unique case (phase_reg)
            PH_HDR1:
            begin
                masked_next = stream_byte[7];
                key_next    = '0;
                count_next  = '0;
                ovf_next    = 1'b0;
                if (code == LEN_CODE_16 || code == LEN_CODE_64)
                begin
                    long_next  = (code == LEN_CODE_64);
                    rem_next   = '0;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    long_next = 1'b0;
                    rem_next  = LENGTH_BITS'(code);
                    if (stream_byte[7])
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        hdr_done  = 1'b1;
                        len_final = LENGTH_BITS'(code);
                    end
                end
            end

            PH_EXTLEN:
            begin
                // bits pushed out of the top make the length saturate
                ovf_next   = ovf_reg | (|rem_reg[LENGTH_BITS-1:LENGTH_BITS-8]);
                count_next = count_reg + 3'd1;
                rem_next   = shifted;
                if (long_reg ? (count_reg == EXT64_LAST) : (count_reg == EXT16_LAST))
                begin
                    len_sat    = ovf_next ? '1 : shifted;
                    rem_next   = len_sat;
                    count_next = '0;
                    if (masked_reg)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        hdr_done  = 1'b1;
                        len_final = len_sat;
                    end
                end
            end

            PH_KEY:
            begin
                key_next   = {key_reg[23:0], stream_byte};
                count_next = count_reg + 3'd1;
                if (count_reg == KEY_LAST)
                begin
                    hdr_done  = 1'b1;
                    len_final = rem_reg;
                end
            end

            PH_PAYLOAD:
            begin
                if (masked_reg)
                begin
                    case (pos_reg)
                        2'd0:    key_byte = key_reg[31:24];
                        2'd1:    key_byte = key_reg[23:16];
                        2'd2:    key_byte = key_reg[15:8];
                        default: key_byte = key_reg[7:0];
                    endcase
                end
                pos_next            = pos_reg + 2'd1;
                rem_next            = rem_reg - LENGTH_BITS'(1);
                emit                = 1'b1;
                result.payload_byte = stream_byte ^ key_byte;
                result.has_data     = 1'b1;
                if (rem_reg == LENGTH_BITS'(1))
                begin
                    result.end_of_frame = 1'b1;
                    phase_next          = PH_HDR0;
                end
            end

            default:
            begin
                fin_next    = stream_byte[7];
                opcode_next = stream_byte[3:0];
                count_next  = '0;
                phase_next  = PH_HDR1;
            end
        endcase

        // Header complete: start payload, or report an empty frame
        if (hdr_done)
        begin
            count_next = '0;
            pos_next   = '0;
            rem_next   = len_final;
            if (len_final == '0)
            begin
                phase_next          = PH_HDR0;
                emit                = 1'b1;
                result.end_of_frame = 1'b1;
            end
            else
            begin
                phase_next = PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            count_reg  <= '0;
            rem_reg    <= '0;
            ovf_reg    <= 1'b0;
            key_reg    <= '0;
            pos_reg    <= '0;
            opcode_reg <= '0;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
            long_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            rem_reg    <= rem_next;
            ovf_reg    <= ovf_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
            long_reg   <= long_next;
        end
    end

    // Payload phase always has bytes left to take
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> rem_reg != '0)
        else $error("payload phase with zero remaining length");

    // First header byte always leads to the second
    a_hdr0_to_hdr1: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_HDR0 |=> phase_reg == PH_HDR1)
        else $error("first header byte did not advance to second");

    // A frame's last result returns the parser to the first header byte
    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit && result.end_of_frame |=> phase_reg == PH_HDR0)
        else $error("end of frame did not restart header parse");

endmodule

@@ hw/rtl/wsd_result_reg.sv @@
module wsd_result_reg
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  out_item_t  item,
    output logic       can_load,
    wsd_stream_if.source frames
);

    logic      valid_reg;
    out_item_t item_reg;

    // Register may refill in the cycle its transaction leaves
    assign can_load       = !valid_reg || frames.ready;
    assign frames.valid   = valid_reg;
    assign frames.payload = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            item_reg <= item;
        end
    end

endmodule

@@ hw/rtl/websocket_frame_deframer_top.sv @@
// Channel  Dir   Payload                                             Transaction
// stream   in    stream_byte[7:0]                                    valid & ready
// frames   out   payload_byte[7:0], has_data, frame_opcode[3:0],     valid & ready
//                final_fragment, end_of_frame
//
// One byte per cycle unless frames stalls; results show on frames in the next cycle.
// Header bytes and payload bytes are all taken at that rate; the result register
// is the only storage between input and output.
// Reset: asynchronous, active low; parser returns to the first header byte.
// stream.ready drops only while frames holds a result that is not taken.
module websocket_frame_deframer_top
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = 64
) (
    input  logic clk,
    input  logic rst_n,
    wsd_stream_if.sink   stream,
    wsd_stream_if.source frames
);

    logic      accept;
    logic      can_load;
    logic      emit;
    out_item_t result;

    assign stream.ready = can_load;
    assign accept       = stream.valid && can_load;

    wsd_frame_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .stream_byte (stream.payload.stream_byte),
        .emit        (emit),
        .result      (result)
    );

    wsd_result_reg u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && emit),
        .item     (result),
        .can_load (can_load),
        .frames   (frames)
    );

endmodule

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam int LEN_BITS = 64;
    localparam logic [63:0] LEN_MAX =
        (LEN_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LEN_BITS) - 64'd1);

    // Frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;
    localparam logic [3:0] OP_RSVD_F = 4'hF;

    localparam out_item_t NO_RESULT = '0;
    localparam int PHASE_BYTES = 80;

    typedef enum logic [2:0] {
        AWAIT_FIN_OP   = 3'd0,
        AWAIT_LEN_CODE = 3'd1,
        EXT_LENGTH     = 3'd2,
        MASK_KEY       = 3'd3,
        PAYLOAD        = 3'd4
    } parse_phase_e;

    typedef struct {
        logic [7:0] raw;
        bit         typed;
        out_item_t  want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    wsd_stream_if #(.payload_t(in_item_t))  stream_ch ();
    wsd_stream_if #(.payload_t(out_item_t)) frames_ch ();

    websocket_frame_deframer_top #(
        .LENGTH_BITS (LEN_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .frames (frames_ch)
    );

    // Directed frames; typed rows carry a result that is obvious from the bytes
    localparam int PLAN_ROWS = 31;
    plan_row_t plan [PLAN_ROWS] = '{
        // empty text frame right after reset
        '{{1'b1, 3'b000, OP_TEXT}, 1'b0, NO_RESULT},
        '{{1'b0, 7'd0}, 1'b1, '{8'h00, 1'b0, OP_TEXT, 1'b1, 1'b1}},
        // FIN clear, all RSV bits set, reserved opcode, masked empty frame
        '{{1'b0, 3'b111, OP_RSVD_F}, 1'b0, NO_RESULT},
        '{{1'b1, 7'd0}, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{8'h00, 1'b0, OP_RSVD_F, 1'b0, 1'b1}},
        // one unmasked byte at the top of the range
        '{{1'b1, 3'b000, OP_BINARY}, 1'b0, NO_RESULT},
        '{{1'b0, 7'd1}, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, '{8'hFF, 1'b1, OP_BINARY, 1'b1, 1'b1}},
        // close frame, 16-bit length, masked
        '{{1'b0, 3'b000, OP_CLOSE}, 1'b0, NO_RESULT},
        '{{1'b1, LEN_CODE_16}, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, NO_RESULT},
        '{8'h12, 1'b0, NO_RESULT},
        '{8'h34, 1'b0, NO_RESULT},
        '{8'h56, 1'b0, NO_RESULT},
        '{8'h78, 1'b0, NO_RESULT},
        '{8'hAB, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        // ping with a 64-bit length of zero
        '{{1'b1, 3'b000, OP_PING}, 1'b0, NO_RESULT},
        '{{1'b0, LEN_CODE_64}, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{8'h00, 1'b0, OP_PING, 1'b1, 1'b1}}
    };

    // Parser state as the testbench tracks it
    parse_phase_e parse_at   = AWAIT_FIN_OP;
    logic [2:0]   field_idx  = '0;
    logic [63:0]  len_left   = '0;
    logic [31:0]  key_word   = '0;
    logic [1:0]   key_idx    = '0;
    logic [3:0]   cur_opcode = '0;
    logic         cur_fin    = 1'b0;
    logic         cur_masked = 1'b0;
    logic         cur_long   = 1'b0;

    out_item_t unmasked_due [$];

    int send_gap_pct;
    int recv_stall_pct;
    int bytes_sent;
    int frames_sent;
    int results_seen;
    int empty_seen;
    int mismatches;

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Header fully read: either start payload or report an empty frame
    function automatic bit finish_header(output out_item_t r);
        field_idx = '0;
        key_idx   = '0;
        r         = NO_RESULT;
        if (len_left == 64'd0)
        begin
            parse_at = AWAIT_FIN_OP;
            r = '{payload_byte: 8'h00, has_data: 1'b0, frame_opcode: cur_opcode,
                  final_fragment: cur_fin, end_of_frame: 1'b1};
            return 1'b1;
        end
        parse_at = PAYLOAD;
        return 1'b0;
    endfunction

    // Length known: masking key next, or the header is done
    function automatic bit close_length(output out_item_t r);
        field_idx = '0;
        r         = NO_RESULT;
        if (cur_masked)
        begin
            parse_at = MASK_KEY;
            return 1'b0;
        end
        return finish_header(r);
    endfunction

    // Advance the tracked parser by one byte; returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, output out_item_t r);
        logic [6:0] code;
        logic [2:0] last_idx;
        logic [7:0] key_byte;
        r = NO_RESULT;
        case (parse_at)
            AWAIT_LEN_CODE:
            begin
                cur_masked = b[7];
                code       = b[6:0];
                key_word   = '0;
                field_idx  = '0;
                if (code == LEN_CODE_16 || code == LEN_CODE_64)
                begin
                    cur_long = (code == LEN_CODE_64);
                    len_left = '0;
                    parse_at = EXT_LENGTH;
                    return 1'b0;
                end
                cur_long = 1'b0;
                len_left = 64'(code);
                return close_length(r);
            end
            EXT_LENGTH:
            begin
                len_left = {len_left[55:0], b};
                last_idx = cur_long ? EXT64_LAST : EXT16_LAST;
                if (field_idx != last_idx)
                begin
                    field_idx = field_idx + 3'd1;
                    return 1'b0;
                end
                if (len_left > LEN_MAX)
                    len_left = LEN_MAX;
                return close_length(r);
            end
            MASK_KEY:
            begin
                key_word = {key_word[23:0], b};
                if (field_idx != KEY_LAST)
                begin
                    field_idx = field_idx + 3'd1;
                    return 1'b0;
                end
                return finish_header(r);
            end
            PAYLOAD:
            begin
                // key bytes are used in arrival order, first byte in bits 31..24
                key_byte = cur_masked ? key_word[8 * (3 - int'(key_idx)) +: 8] : 8'h00;
                key_idx  = key_idx + 2'd1;
                len_left = (len_left - 64'd1) & LEN_MAX;
                r = '{payload_byte: b ^ key_byte, has_data: 1'b1,
                      frame_opcode: cur_opcode, final_fragment: cur_fin,
                      end_of_frame: (len_left == 64'd0)};
                if (len_left == 64'd0)
                    parse_at = AWAIT_FIN_OP;
                return 1'b1;
            end
            default:
            begin
                cur_fin    = b[7];
                cur_opcode = b[3:0];
                field_idx  = '0;
                parse_at   = AWAIT_LEN_CODE;
                return 1'b0;
            end
        endcase
    endfunction

    // Offer one byte, with random gaps; called and returns at a falling edge
    task automatic push_byte(input logic [7:0] b, input bit typed, input out_item_t want);
        out_item_t r;
        bit        gives;
        while ($urandom_range(99) < send_gap_pct)
        begin
            stream_ch.valid <= 1'b0;
            @(negedge clk);
        end
        stream_ch.valid               <= 1'b1;
        stream_ch.payload.stream_byte <= b;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
        gives = deframe_byte(b, r);
        if (typed)
        begin
            gives = 1'b1;
            r     = want;
        end
        if (gives)
            unmasked_due = {unmasked_due, r};
        bytes_sent++;
        @(negedge clk);
    endtask

    // One well-formed frame with random header fields, length, key and data
    task automatic send_frame();
        logic [3:0]  op;
        logic [63:0] len;
        bit          masked;
        int unsigned pick;
        case ($urandom_range(8))
            0:       op = OP_CONT;
            1:       op = OP_TEXT;
            2:       op = OP_BINARY;
            3:       op = OP_CLOSE;
            4:       op = OP_PING;
            5:       op = OP_PONG;
            default: op = 4'($urandom);
        endcase
        push_byte({1'($urandom), 3'($urandom), op}, 1'b0, NO_RESULT);
        masked = ($urandom_range(3) != 0);
        pick   = $urandom_range(99);
        if (pick < 76)
        begin
            len = (pick < 70) ? 64'($urandom_range(8)) : 64'($urandom_range(125, 9));
            push_byte({masked, len[6:0]}, 1'b0, NO_RESULT);
        end
        else if (pick < 92)
        begin
            len = ($urandom_range(5) == 0) ? 64'($urandom_range(300, 126))
                                           : 64'($urandom_range(40));
            push_byte({masked, LEN_CODE_16}, 1'b0, NO_RESULT);
            push_byte(len[15:8], 1'b0, NO_RESULT);
            push_byte(len[7:0], 1'b0, NO_RESULT);
        end
        else
        begin
            len = 64'($urandom_range(24));
            push_byte({masked, LEN_CODE_64}, 1'b0, NO_RESULT);
            for (int i = 7; i >= 0; i--)
                push_byte(len[8 * i +: 8], 1'b0, NO_RESULT);
        end
        if (masked)
            repeat (4) push_byte(8'($urandom), 1'b0, NO_RESULT);
        repeat (int'(len)) push_byte(8'($urandom), 1'b0, NO_RESULT);
        frames_sent++;
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("tb: result %0d: %s expected %0h got %0h", results_seen, what, want, got);
    endtask

    // Receiver back-pressure
    initial
    begin
        frames_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            frames_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && frames_ch.valid && frames_ch.ready)
        begin
            got = frames_ch.payload;
            results_seen++;
            if (got.has_data === 1'b0)
                empty_seen++;
            if (unmasked_due.size() == 0)
                flag_mismatch("nothing pending, payload_byte", 8'h00, got.payload_byte);
            else
            begin
                want = unmasked_due.pop_front();
                if (got.payload_byte !== want.payload_byte)
                    flag_mismatch("payload_byte", want.payload_byte, got.payload_byte);
                if (got.has_data !== want.has_data)
                    flag_mismatch("has_data", 8'(want.has_data), 8'(got.has_data));
                if (got.frame_opcode !== want.frame_opcode)
                    flag_mismatch("frame_opcode", 8'(want.frame_opcode),
                                  8'(got.frame_opcode));
                if (got.final_fragment !== want.final_fragment)
                    flag_mismatch("final_fragment", 8'(want.final_fragment),
                                  8'(got.final_fragment));
                if (got.end_of_frame !== want.end_of_frame)
                    flag_mismatch("end_of_frame", 8'(want.end_of_frame),
                                  8'(got.end_of_frame));
            end
        end
    end

    // Hang guard
    initial
    begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Stimulus and wrap-up
    initial
    begin
        int start_bytes;
        int waited;
        stream_ch.valid   = 1'b0;
        stream_ch.payload = '0;
        rst_n             = 1'b0;
        send_gap_pct      = 36;
        recv_stall_pct    = 65;
        bytes_sent        = 0;
        frames_sent       = 0;
        results_seen      = 0;
        empty_seen        = 0;
        mismatches        = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames
        for (int i = 0; i < PLAN_ROWS; i++)
            push_byte(plan[i].raw, plan[i].typed, plan[i].want);

        // random frames under three idle mixes
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_gap_pct   = 36;
                    recv_stall_pct = 65;
                end
                1:
                begin
                    send_gap_pct   = 65;
                    recv_stall_pct = 36;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES)
                send_frame();
        end

        // last frame: all-ones 64-bit length (top bit set), never completes
        push_byte({1'b0, 3'b000, OP_BINARY}, 1'b0, NO_RESULT);
        push_byte({1'b1, LEN_CODE_64}, 1'b0, NO_RESULT);
        repeat (8) push_byte(8'hFF, 1'b0, NO_RESULT);
        repeat (4) push_byte(8'($urandom), 1'b0, NO_RESULT);
        repeat (40) push_byte(8'($urandom), 1'b0, NO_RESULT);
        stream_ch.valid <= 1'b0;

        // drain, then allow for the result register
        waited = 0;
        while (unmasked_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (unmasked_due.size() != 0)
        begin
            $display("tb: %0d expected results never arrived", unmasked_due.size());
            mismatches += unmasked_due.size();
        end

        $display("tb: %0d bytes in, %0d random frames plus directed ones, %0d results (%0d empty)",
                 bytes_sent, frames_sent, results_seen, empty_seen);
        $display("tb: %0d mismatches; idle mixes 36/65, 65/36, 0/0; ended on a huge 64-bit length",
                 mismatches);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
